FILE: src/lcdseq_pkg.sv
package lcdseq_pkg;

    localparam int ActionW = 2;
    localparam int ByteW   = 8;
    localparam int NibW    = 4;
    localparam int HoldW   = 16;
    localparam int PulseW  = 10;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 16;
    localparam int PcW     = 6;

    localparam logic [ActionW-1:0] ActCmd  = 2'd0;
    localparam logic [ActionW-1:0] ActData = 2'd1;
    localparam logic [ActionW-1:0] ActInit = 2'd2;
    localparam logic [ActionW-1:0] ActNone = 2'd3;

    localparam logic [CfgAddrW-1:0] CfgEPulse  = 3'd0;
    localparam logic [CfgAddrW-1:0] CfgCmdWait = 3'd1;
    localparam logic [CfgAddrW-1:0] CfgDataWait = 3'd2;
    localparam logic [CfgAddrW-1:0] CfgLongWait = 3'd3;
    localparam logic [CfgAddrW-1:0] CfgPowerWait = 3'd4;

    localparam logic [PulseW-1:0] EPulseRst    = 10'd25;
    localparam logic [HoldW-1:0]  CmdWaitRst   = 16'd39;
    localparam logic [HoldW-1:0]  DataWaitRst  = 16'd43;
    localparam logic [HoldW-1:0]  LongWaitRst  = 16'd1600;
    localparam logic [HoldW-1:0]  PowerWaitRst = 16'd40000;

    // nibble source
    localparam logic [1:0] NibConst = 2'd0;
    localparam logic [1:0] NibHigh  = 2'd1;
    localparam logic [1:0] NibLow   = 2'd2;

    // hold source
    localparam logic [2:0] HoldZero  = 3'd0;
    localparam logic [2:0] HoldPulse = 3'd1;
    localparam logic [2:0] HoldPower = 3'd2;
    localparam logic [2:0] HoldCmd   = 3'd3;
    localparam logic [2:0] HoldLong  = 3'd4;
    localparam logic [2:0] HoldByte  = 3'd5;

    localparam logic [PcW-1:0] EntryByte = 6'd0;
    localparam logic [PcW-1:0] EntryInit = 6'd6;
    localparam logic [PcW-1:0] UcodeLast = 6'd33;

    typedef struct packed {
        logic [1:0]      nib_sel;
        logic [NibW-1:0] nib_const;
        logic            en;
        logic [2:0]      hold_sel;
        logic            last;
    } ucode_t;

    typedef struct packed {
        logic             fire;
        ucode_t           word;
        logic [ByteW-1:0] byte_val;
        logic             rs;
    } step_ctl_t;

    function automatic ucode_t uw(input logic [1:0] sel, input logic [NibW-1:0] nib,
                                  input logic en, input logic [2:0] hold,
                                  input logic last);
        ucode_t w;
        w.nib_sel   = sel;
        w.nib_const = nib;
        w.en        = en;
        w.hold_sel  = hold;
        w.last      = last;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
        ucode_t w;
        case (pc)
            // byte program
            6'd0:  w = uw(NibHigh, 4'h0, 1'b0, HoldZero, 1'b0);
            6'd1:  w = uw(NibHigh, 4'h0, 1'b1, HoldPulse, 1'b0);
            6'd2:  w = uw(NibHigh, 4'h0, 1'b0, HoldZero, 1'b0);
            6'd3:  w = uw(NibLow, 4'h0, 1'b0, HoldZero, 1'b0);
            6'd4:  w = uw(NibLow, 4'h0, 1'b1, HoldPulse, 1'b0);
            6'd5:  w = uw(NibLow, 4'h0, 1'b0, HoldByte, 1'b1);
            // init program
            6'd6:  w = uw(NibConst, 4'h0, 1'b0, HoldPower, 1'b0);
            6'd7:  w = uw(NibConst, 4'h2, 1'b0, HoldZero, 1'b0);
            6'd8:  w = uw(NibConst, 4'h2, 1'b1, HoldPulse, 1'b0);
            6'd9:  w = uw(NibConst, 4'h2, 1'b0, HoldZero, 1'b0);
            6'd10: w = uw(NibConst, 4'h2, 1'b0, HoldZero, 1'b0);
            6'd11: w = uw(NibConst, 4'h2, 1'b1, HoldPulse, 1'b0);
            6'd12: w = uw(NibConst, 4'h2, 1'b0, HoldZero, 1'b0);
            6'd13: w = uw(NibConst, 4'h8, 1'b0, HoldZero, 1'b0);
            6'd14: w = uw(NibConst, 4'h8, 1'b1, HoldPulse, 1'b0);
            6'd15: w = uw(NibConst, 4'h8, 1'b0, HoldCmd, 1'b0);
            6'd16: w = uw(NibConst, 4'h0, 1'b0, HoldZero, 1'b0);
            6'd17: w = uw(NibConst, 4'h0, 1'b1, HoldPulse, 1'b0);
            6'd18: w = uw(NibConst, 4'h0, 1'b0, HoldZero, 1'b0);
            6'd19: w = uw(NibConst, 4'h8, 1'b0, HoldZero, 1'b0);
            6'd20: w = uw(NibConst, 4'h8, 1'b1, HoldPulse, 1'b0);
            6'd21: w = uw(NibConst, 4'h8, 1'b0, HoldCmd, 1'b0);
            6'd22: w = uw(NibConst, 4'h0, 1'b0, HoldZero, 1'b0);
            6'd23: w = uw(NibConst, 4'h0, 1'b1, HoldPulse, 1'b0);
            6'd24: w = uw(NibConst, 4'h0, 1'b0, HoldZero, 1'b0);
            6'd25: w = uw(NibConst, 4'h1, 1'b0, HoldZero, 1'b0);
            6'd26: w = uw(NibConst, 4'h1, 1'b1, HoldPulse, 1'b0);
            6'd27: w = uw(NibConst, 4'h1, 1'b0, HoldLong, 1'b0);
            6'd28: w = uw(NibConst, 4'h0, 1'b0, HoldZero, 1'b0);
            6'd29: w = uw(NibConst, 4'h0, 1'b1, HoldPulse, 1'b0);
            6'd30: w = uw(NibConst, 4'h0, 1'b0, HoldZero, 1'b0);
            6'd31: w = uw(NibConst, 4'h6, 1'b0, HoldZero, 1'b0);
            6'd32: w = uw(NibConst, 4'h6, 1'b1, HoldPulse, 1'b0);
            6'd33: w = uw(NibConst, 4'h6, 1'b0, HoldCmd, 1'b1);
            default: w = uw(NibConst, 4'h0, 1'b0, HoldZero, 1'b1);
        endcase
        return w;
    endfunction

endpackage

FILE: src/lcdseq_sequencer.sv
module lcdseq_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              req_valid,
    input  logic [lcdseq_pkg::ActionW-1:0]    req_action,
    input  logic [lcdseq_pkg::ByteW-1:0]      req_byte,
    output logic                              req_ready,
    input  logic                              slot_free,
    output lcdseq_pkg::step_ctl_t             ctl
);

    logic                          busy_reg, busy_next;
    logic [lcdseq_pkg::PcW-1:0]    pc_reg, pc_next;
    logic [lcdseq_pkg::ByteW-1:0]  byte_reg, byte_next;
    logic                          rs_reg, rs_next;
    logic                          accept;
    lcdseq_pkg::ucode_t            word;

    assign req_ready = !busy_reg;
    assign accept    = req_valid && !busy_reg;
    assign word      = lcdseq_pkg::ucode_rom(pc_reg);

    assign ctl.fire     = busy_reg && slot_free;
    assign ctl.word     = word;
    assign ctl.byte_val = byte_reg;
    assign ctl.rs       = rs_reg;

    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        byte_next = byte_reg;
        rs_next   = rs_reg;
        if (accept) begin
            byte_next = req_byte;
            case (req_action)
                lcdseq_pkg::ActCmd: begin
                    busy_next = 1'b1;
                    pc_next   = lcdseq_pkg::EntryByte;
                    rs_next   = 1'b0;
                end
                lcdseq_pkg::ActData: begin
                    busy_next = 1'b1;
                    pc_next   = lcdseq_pkg::EntryByte;
                    rs_next   = 1'b1;
                end
                lcdseq_pkg::ActInit: begin
                    busy_next = 1'b1;
                    pc_next   = lcdseq_pkg::EntryInit;
                    rs_next   = 1'b0;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end else if (ctl.fire) begin
            if (word.last) begin
                busy_next = 1'b0;
            end else begin
                pc_next = pc_reg + {{(lcdseq_pkg::PcW-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= lcdseq_pkg::EntryByte;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
        byte_reg <= byte_next;
        rs_reg   <= rs_next;
    end

    a_pc_in_rom: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pc_reg <= lcdseq_pkg::UcodeLast)
        else $error("step counter ran past the program");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fire && word.last |=> !busy_reg)
        else $error("sequencer still busy after last step");

    a_unused_action: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && req_action == lcdseq_pkg::ActNone |=> !busy_reg)
        else $error("unused action started a program");

    a_init_no_rs: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && pc_reg >= lcdseq_pkg::EntryInit |-> !rs_reg)
        else $error("RS set during init program");

endmodule

FILE: src/lcdseq_datapath.sv
module lcdseq_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lcdseq_pkg::CfgAddrW-1:0]    cfg_addr,
    input  logic [lcdseq_pkg::CfgDataW-1:0]    cfg_wdata,
    input  lcdseq_pkg::step_ctl_t              ctl,
    input  logic                               out_ready,
    output logic                               slot_free,
    output logic                               out_valid,
    output logic [lcdseq_pkg::NibW-1:0]        out_nibble,
    output logic                               out_rs,
    output logic                               out_en,
    output logic [lcdseq_pkg::HoldW-1:0]       out_hold,
    output logic                               out_last
);

    logic [lcdseq_pkg::PulseW-1:0] e_pulse_reg;
    logic [lcdseq_pkg::HoldW-1:0]  cmd_wait_reg;
    logic [lcdseq_pkg::HoldW-1:0]  data_wait_reg;
    logic [lcdseq_pkg::HoldW-1:0]  long_wait_reg;
    logic [lcdseq_pkg::HoldW-1:0]  power_wait_reg;

    logic                          valid_reg, valid_next;
    logic [lcdseq_pkg::NibW-1:0]   nib_reg, nib_next;
    logic                          rs_reg;
    logic                          en_reg;
    logic [lcdseq_pkg::HoldW-1:0]  hold_reg, hold_next;
    logic                          last_reg;
    logic [lcdseq_pkg::HoldW-1:0]  byte_wait;

    assign slot_free = !valid_reg || out_ready;

    always_comb begin
        if (ctl.rs) begin
            byte_wait = data_wait_reg;
        end else if (ctl.byte_val >= 8'd1 && ctl.byte_val <= 8'd3) begin
            byte_wait = long_wait_reg;
        end else begin
            byte_wait = cmd_wait_reg;
        end
    end

    always_comb begin
        case (ctl.word.nib_sel)
            lcdseq_pkg::NibHigh: nib_next = ctl.byte_val[7:4];
            lcdseq_pkg::NibLow:  nib_next = ctl.byte_val[3:0];
            default:             nib_next = ctl.word.nib_const;
        endcase
        case (ctl.word.hold_sel)
            lcdseq_pkg::HoldPulse: hold_next = {{(lcdseq_pkg::HoldW-lcdseq_pkg::PulseW){1'b0}},
                                                e_pulse_reg};
            lcdseq_pkg::HoldPower: hold_next = power_wait_reg;
            lcdseq_pkg::HoldCmd:   hold_next = cmd_wait_reg;
            lcdseq_pkg::HoldLong:  hold_next = long_wait_reg;
            lcdseq_pkg::HoldByte:  hold_next = byte_wait;
            default:               hold_next = '0;
        endcase
        valid_next = ctl.fire || (valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_pulse_reg    <= lcdseq_pkg::EPulseRst;
            cmd_wait_reg   <= lcdseq_pkg::CmdWaitRst;
            data_wait_reg  <= lcdseq_pkg::DataWaitRst;
            long_wait_reg  <= lcdseq_pkg::LongWaitRst;
            power_wait_reg <= lcdseq_pkg::PowerWaitRst;
            valid_reg      <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    lcdseq_pkg::CfgEPulse:    e_pulse_reg    <= cfg_wdata[lcdseq_pkg::PulseW-1:0];
                    lcdseq_pkg::CfgCmdWait:   cmd_wait_reg   <= cfg_wdata;
                    lcdseq_pkg::CfgDataWait:  data_wait_reg  <= cfg_wdata;
                    lcdseq_pkg::CfgLongWait:  long_wait_reg  <= cfg_wdata;
                    lcdseq_pkg::CfgPowerWait: power_wait_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        if (ctl.fire) begin
            nib_reg  <= nib_next;
            rs_reg   <= ctl.rs;
            en_reg   <= ctl.word.en;
            hold_reg <= hold_next;
            last_reg <= ctl.word.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_nibble = nib_reg;
    assign out_rs     = rs_reg;
    assign out_en     = en_reg;
    assign out_hold   = hold_reg;
    assign out_last   = last_reg;

endmodule

FILE: src/char_lcd_nibble_write_sequencer_unit.sv
// Character LCD 4-bit bus sequencer. A request asks for a command byte
// (tuser 0), a data byte (tuser 1) or the power-on init sequence (tuser 2);
// tuser 3 is taken and ignored. Each result is one pin state with the time
// to hold it. Command and data requests give 6 results, init gives 28, one
// result per cycle while the output is taken. A small microcode table and
// step counter drive the steps; a new request is accepted once the previous
// program has handed its last step to the output register. Timing registers
// are to be written through cfg_we/cfg_addr/cfg_wdata only while idle by the
// user; the block itself does not enforce this.
module char_lcd_nibble_write_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] bus_nibble, [4] enable_line, [20:5] hold_us
    output logic        m_tuser,   // [0] reg_select
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    lcdseq_pkg::step_ctl_t          ctl;
    logic                           slot_free;
    logic [lcdseq_pkg::NibW-1:0]    nibble;
    logic                           enable;
    logic [lcdseq_pkg::HoldW-1:0]   hold;

    lcdseq_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_action (s_tuser),
        .req_byte   (s_tdata),
        .req_ready  (s_tready),
        .slot_free  (slot_free),
        .ctl        (ctl)
    );

    lcdseq_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .ctl        (ctl),
        .out_ready  (m_tready),
        .slot_free  (slot_free),
        .out_valid  (m_tvalid),
        .out_nibble (nibble),
        .out_rs     (m_tuser),
        .out_en     (enable),
        .out_hold   (hold),
        .out_last   (m_tlast)
    );

    assign m_tdata = {3'b000, hold, enable, nibble};

endmodule
